// ===== src/lmgp_pkg.sv =====
// ----------------------------------------------------------------------------
// lmgp_pkg: glyph plotter types, constants and font ROM
// Shared word types and the point-list font used by the glyph plotter core.
// ----------------------------------------------------------------------------
package lmgp_pkg;

  localparam int unsigned FirstCode    = 33;
  localparam int unsigned SpaceCode    = 32;
  localparam int unsigned SpaceAdvance = 5;
  localparam int unsigned MaxPoints    = 17;
  localparam logic [7:0]  EndMark      = 8'hFF;

  typedef struct packed {
    logic [7:0] character_code;
    logic [7:0] origin_col;
    logic [7:0] origin_row;
    logic       pixel_value;
    logic       mode;
  } cmd_t;

  typedef struct packed {
    logic       pixel_write;
    logic [3:0] pixel_col;
    logic [3:0] pixel_row;
    logic       pixel_level;
    logic [2:0] advance;
    logic       last;
  } res_t;

  // Glyph slot for a code; slot 0 means no glyph.
  function automatic logic [6:0] glyph_slot(input logic [7:0] code);
    logic [6:0] s;
    s = 7'd0;
    case (code)
      8'd33: s = 7'd1;  8'd39: s = 7'd2;  8'd44: s = 7'd3;
      default: begin
        if (code >= 8'd48 && code <= 8'd57) s = 7'(code - 8'd44);
        else if (code >= 8'd65 && code <= 8'd90) s = 7'(code - 8'd51);
        else if (code >= 8'd97 && code <= 8'd122) s = 7'(code - 8'd57);
      end
    endcase
    return s;
  endfunction

  // Point list of a glyph slot: 18 entries, terminated by EndMark.
  function automatic logic [8*18-1:0] glyph_pts(input logic [6:0] s);
    logic [8*18-1:0] p;
    p = '1;
    case (s)
      7'd1:  p[8*6-1:0]  = {8'h17,8'h15,8'h14,8'h13,8'h12,8'h11};
      7'd2:  p[8*3-1:0]  = {8'h22,8'h21,8'h13};
      7'd3:  p[8*3-1:0]  = {8'h26,8'h25,8'h17};
      7'd4:  p[8*16-1:0] = {8'h46,8'h45,8'h44,8'h43,8'h42,8'h37,8'h31,8'h27,
                            8'h21,8'h17,8'h11,8'h06,8'h05,8'h04,8'h03,8'h02};
      7'd5:  p[8*10-1:0] = {8'h37,8'h27,8'h26,8'h25,8'h24,8'h23,8'h22,8'h21,
                            8'h17,8'h12};
      7'd6:  p[8*16-1:0] = {8'h47,8'h43,8'h42,8'h37,8'h34,8'h31,8'h27,8'h24,
                            8'h21,8'h17,8'h14,8'h11,8'h07,8'h06,8'h05,8'h02};
      7'd7:  p[8*15-1:0] = {8'h46,8'h45,8'h43,8'h42,8'h37,8'h34,8'h31,8'h27,
                            8'h24,8'h21,8'h17,8'h14,8'h11,8'h06,8'h02};
      7'd8:  p[8*14-1:0] = {8'h45,8'h37,8'h36,8'h35,8'h34,8'h33,8'h32,8'h31,
                            8'h25,8'h22,8'h15,8'h13,8'h05,8'h04};
      7'd9:  p[8*17-1:0] = {8'h46,8'h45,8'h41,8'h37,8'h34,8'h31,8'h27,8'h24,
                            8'h21,8'h17,8'h14,8'h11,8'h07,8'h04,8'h03,8'h02,8'h01};
      7'd10: p[8*17-1:0] = {8'h46,8'h45,8'h42,8'h37,8'h34,8'h31,8'h27,8'h24,
                            8'h21,8'h17,8'h14,8'h11,8'h06,8'h05,8'h04,8'h03,8'h02};
      7'd11: p[8*11-1:0] = {8'h42,8'h41,8'h34,8'h33,8'h31,8'h27,8'h26,8'h25,
                            8'h21,8'h11,8'h01};
      7'd12: p[8*17-1:0] = {8'h46,8'h45,8'h43,8'h42,8'h37,8'h34,8'h31,8'h27,
                            8'h24,8'h21,8'h17,8'h14,8'h11,8'h06,8'h05,8'h03,8'h02};
      7'd13: p[8*17-1:0] = {8'h46,8'h45,8'h44,8'h43,8'h42,8'h37,8'h34,8'h31,
                            8'h27,8'h24,8'h21,8'h17,8'h14,8'h11,8'h07,8'h03,8'h02};
      7'd14: p[8*16-1:0] = {8'h37,8'h36,8'h35,8'h34,8'h33,8'h32,8'h24,8'h21,
                            8'h14,8'h11,8'h07,8'h06,8'h05,8'h04,8'h03,8'h02};
      7'd15: p[8*17-1:0] = {8'h36,8'h35,8'h33,8'h32,8'h27,8'h24,8'h21,8'h17,
                            8'h14,8'h11,8'h07,8'h06,8'h05,8'h04,8'h03,8'h02,8'h01};
      7'd16: p[8*11-1:0] = {8'h36,8'h32,8'h27,8'h21,8'h17,8'h11,8'h06,8'h05,
                            8'h04,8'h03,8'h02};
      7'd17: p[8*16-1:0] = {8'h36,8'h35,8'h34,8'h33,8'h32,8'h27,8'h21,8'h17,
                            8'h11,8'h07,8'h06,8'h05,8'h04,8'h03,8'h02,8'h01};
      7'd18: p[8*15-1:0] = {8'h37,8'h31,8'h27,8'h24,8'h21,8'h17,8'h14,8'h11,
                            8'h07,8'h06,8'h05,8'h04,8'h03,8'h02,8'h01};
      7'd19: p[8*12-1:0] = {8'h31,8'h24,8'h21,8'h14,8'h11,8'h07,8'h06,8'h05,
                            8'h04,8'h03,8'h02,8'h01};
      7'd20: p[8*14-1:0] = {8'h37,8'h36,8'h35,8'h32,8'h27,8'h25,8'h21,8'h17,
                            8'h11,8'h06,8'h05,8'h04,8'h03,8'h02};
      7'd21: p[8*16-1:0] = {8'h37,8'h36,8'h35,8'h34,8'h33,8'h32,8'h31,8'h24,
                            8'h14,8'h07,8'h06,8'h05,8'h04,8'h03,8'h02,8'h01};
      7'd22: p[8*11-1:0] = {8'h27,8'h21,8'h17,8'h16,8'h15,8'h14,8'h13,8'h12,
                            8'h11,8'h07,8'h01};
      7'd23: p[8*10-1:0] = {8'h31,8'h26,8'h25,8'h24,8'h23,8'h22,8'h21,8'h17,
                            8'h11,8'h07};
      7'd24: p[8*14-1:0] = {8'h37,8'h36,8'h32,8'h31,8'h25,8'h23,8'h14,8'h07,
                            8'h06,8'h05,8'h04,8'h03,8'h02,8'h01};
      7'd25: p[8*10-1:0] = {8'h37,8'h27,8'h17,8'h07,8'h06,8'h05,8'h04,8'h03,
                            8'h02,8'h01};
      7'd26: p[8*17-1:0] = {8'h47,8'h46,8'h45,8'h44,8'h43,8'h42,8'h41,8'h32,
                            8'h23,8'h12,8'h07,8'h06,8'h05,8'h04,8'h03,8'h02,8'h01};
      7'd27: p[8*16-1:0] = {8'h37,8'h36,8'h35,8'h34,8'h33,8'h32,8'h31,8'h24,
                            8'h13,8'h07,8'h06,8'h05,8'h04,8'h03,8'h02,8'h01};
      7'd28: p[8*14-1:0] = {8'h36,8'h35,8'h34,8'h33,8'h32,8'h27,8'h21,8'h17,
                            8'h11,8'h06,8'h05,8'h04,8'h03,8'h02};
      7'd29: p[8*13-1:0] = {8'h33,8'h32,8'h24,8'h21,8'h14,8'h11,8'h07,8'h06,
                            8'h05,8'h04,8'h03,8'h02,8'h01};
      7'd30: p[8*14-1:0] = {8'h37,8'h35,8'h34,8'h33,8'h32,8'h26,8'h21,8'h17,
                            8'h11,8'h06,8'h05,8'h04,8'h03,8'h02};
      7'd31: p[8*16-1:0] = {8'h37,8'h36,8'h33,8'h32,8'h25,8'h24,8'h21,8'h14,
                            8'h11,8'h07,8'h06,8'h05,8'h04,8'h03,8'h02,8'h01};
      7'd32: p[8*12-1:0] = {8'h36,8'h35,8'h32,8'h27,8'h24,8'h21,8'h17,8'h14,
                            8'h11,8'h06,8'h03,8'h02};
      7'd33: p[8*9-1:0]  = {8'h21,8'h17,8'h16,8'h15,8'h14,8'h13,8'h12,8'h11,
                            8'h01};
      7'd34: p[8*14-1:0] = {8'h36,8'h35,8'h34,8'h33,8'h32,8'h31,8'h27,8'h17,
                            8'h06,8'h05,8'h04,8'h03,8'h02,8'h01};
      7'd35: p[8*13-1:0] = {8'h45,8'h44,8'h43,8'h42,8'h41,8'h36,8'h27,8'h16,
                            8'h05,8'h04,8'h03,8'h02,8'h01};
      7'd36: p[8*17-1:0] = {8'h46,8'h45,8'h44,8'h43,8'h42,8'h41,8'h37,8'h26,
                            8'h25,8'h24,8'h17,8'h06,8'h05,8'h04,8'h03,8'h02,8'h01};
      7'd37: p[8*13-1:0] = {8'h47,8'h46,8'h42,8'h41,8'h35,8'h33,8'h24,8'h15,
                            8'h13,8'h07,8'h06,8'h02,8'h01};
      7'd38: p[8*10-1:0] = {8'h42,8'h41,8'h33,8'h27,8'h26,8'h25,8'h24,8'h13,
                            8'h02,8'h01};
      7'd39: p[8*15-1:0] = {8'h47,8'h42,8'h41,8'h37,8'h33,8'h31,8'h27,8'h24,
                            8'h21,8'h17,8'h15,8'h11,8'h07,8'h06,8'h01};
      7'd40: p[8*10-1:0] = {8'h37,8'h36,8'h35,8'h34,8'h27,8'h24,8'h17,8'h14,
                            8'h06,8'h05};
      7'd41: p[8*13-1:0] = {8'h36,8'h35,8'h27,8'h24,8'h17,8'h14,8'h07,8'h06,
                            8'h05,8'h04,8'h03,8'h02,8'h01};
      7'd42: p[8*6-1:0]  = {8'h27,8'h24,8'h17,8'h14,8'h06,8'h05};
      7'd43: p[8*13-1:0] = {8'h37,8'h36,8'h35,8'h34,8'h33,8'h32,8'h31,8'h27,
                            8'h24,8'h17,8'h14,8'h06,8'h05};
      7'd44: p[8*12-1:0] = {8'h37,8'h35,8'h34,8'h27,8'h25,8'h23,8'h17,8'h15,
                            8'h13,8'h06,8'h05,8'h04};
      7'd45: p[8*11-1:0] = {8'h31,8'h24,8'h21,8'h17,8'h16,8'h15,8'h14,8'h13,
                            8'h12,8'h11,8'h04};
      7'd46: p[8*14-1:0] = {8'h37,8'h36,8'h35,8'h34,8'h33,8'h28,8'h26,8'h23,
                            8'h18,8'h16,8'h13,8'h08,8'h05,8'h04};
      7'd47: p[8*12-1:0] = {8'h37,8'h36,8'h35,8'h24,8'h14,8'h07,8'h06,8'h05,
                            8'h04,8'h03,8'h02,8'h01};
      7'd48: p[8*5-1:0]  = {8'h07,8'h06,8'h05,8'h04,8'h02};
      7'd49: p[8*7-1:0]  = {8'h18,8'h17,8'h16,8'h15,8'h14,8'h12,8'h08};
      7'd50: p[8*11-1:0] = {8'h37,8'h26,8'h24,8'h15,8'h07,8'h06,8'h05,8'h04,
                            8'h03,8'h02,8'h01};
      7'd51: p[8*7-1:0]  = {8'h07,8'h06,8'h05,8'h04,8'h03,8'h02,8'h01};
      7'd52: p[8*12-1:0] = {8'h47,8'h46,8'h45,8'h34,8'h27,8'h26,8'h25,8'h14,
                            8'h07,8'h06,8'h05,8'h04};
      7'd53: p[8*9-1:0]  = {8'h37,8'h36,8'h35,8'h24,8'h14,8'h07,8'h06,8'h05,
                            8'h04};
      7'd54: p[8*8-1:0]  = {8'h36,8'h35,8'h27,8'h24,8'h17,8'h14,8'h06,8'h05};
      7'd55: p[8*11-1:0] = {8'h36,8'h35,8'h27,8'h24,8'h17,8'h14,8'h08,8'h07,
                            8'h06,8'h05,8'h04};
      7'd56: p[8*11-1:0] = {8'h38,8'h37,8'h36,8'h35,8'h34,8'h27,8'h24,8'h17,
                            8'h14,8'h06,8'h05};
      7'd57: p[8*6-1:0]  = {8'h24,8'h14,8'h07,8'h06,8'h05,8'h04};
      7'd58: p[8*10-1:0] = {8'h36,8'h33,8'h27,8'h25,8'h23,8'h17,8'h15,8'h13,
                            8'h07,8'h04};
      7'd59: p[8*9-1:0]  = {8'h37,8'h27,8'h24,8'h17,8'h16,8'h15,8'h14,8'h13,
                            8'h04};
      7'd60: p[8*9-1:0]  = {8'h37,8'h36,8'h35,8'h34,8'h27,8'h17,8'h06,8'h05,
                            8'h04};
      7'd61: p[8*7-1:0]  = {8'h26,8'h25,8'h24,8'h17,8'h06,8'h05,8'h04};
      7'd62: p[8*12-1:0] = {8'h47,8'h46,8'h45,8'h44,8'h37,8'h26,8'h25,8'h24,
                            8'h17,8'h06,8'h05,8'h04};
      7'd63: p[8*6-1:0]  = {8'h27,8'h24,8'h16,8'h15,8'h07,8'h04};
      7'd64: p[8*10-1:0] = {8'h38,8'h37,8'h36,8'h35,8'h34,8'h27,8'h17,8'h06,
                            8'h05,8'h04};
      7'd65: p[8*10-1:0] = {8'h37,8'h34,8'h27,8'h25,8'h24,8'h17,8'h16,8'h14,
                            8'h07,8'h04};
      default: p = '1;
    endcase
    return p;
  endfunction

endpackage

// ===== src/led_matrix_glyph_plotter_core.sv =====
// ----------------------------------------------------------------------------
// led_matrix_glyph_plotter_core: LED matrix glyph plotter
// Walks a glyph's point list in a font ROM and emits clipped pixel writes.
// ----------------------------------------------------------------------------
// Usage: drive cmd_i and pulse start while busy is low; the word is taken
// at that edge and busy rises. The core then reads its font ROM (a constant
// table with a registered output, one point per cycle) and, per point
// landing inside the DISPLAY_WIDTH x DISPLAY_HEIGHT display, presents a
// pixel-write word on res_o for one cycle with res_valid_o high. A final
// word with last set carries the advance width (widest column + 2, 5 for a
// space, 0 for an unsupported code). The receiver cannot stall: every word
// shows for exactly one cycle.
// Sequencing: each point is read into the ROM output register, then checked
// and registered as a pixel write; after the terminator read the final word
// is registered, and busy stays high until it has left the output register,
// so no new word is taken before the last glyph is through. Space and
// unsupported codes skip the walk and go straight to the final word.
// Reset clears the control state; the ROM is constant, so nothing needs
// clearing.
// ----------------------------------------------------------------------------
module led_matrix_glyph_plotter_core #(
  parameter int unsigned DISPLAY_WIDTH  = 14,
  parameter int unsigned DISPLAY_HEIGHT = 9,
  parameter int unsigned LAST_CODE      = 90
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start,
  output logic                busy,
  input  lmgp_pkg::cmd_t      cmd_i,
  output logic                res_valid_o,
  output lmgp_pkg::res_t      res_o
);

  typedef enum logic [2:0] {
    StIdle = 3'b001,
    StWalk = 3'b010,
    StDone = 3'b100
  } state_e;

  state_e     state_q, state_d;
  logic [8*18-1:0] glyph_row;
  logic [7:0] rom_q;
  logic [4:0] idx_q, idx_d;
  logic [6:0] slot_q, slot_d;
  logic       rd_q, rd_d;        // rom_q holds a point of this item
  lmgp_pkg::cmd_t cmd_q, cmd_d;
  logic [2:0] widest_q, widest_d;
  logic [2:0] fin_adv_q, fin_adv_d;
  logic       fin_q, fin_d;
  lmgp_pkg::res_t res_q, res_d;
  logic       res_v_q, res_v_d;

  // Font ROM: one glyph row per slot, one point out per cycle.
  assign glyph_row = lmgp_pkg::glyph_pts(slot_q);

  always_ff @(posedge clk_i) begin
    if (idx_q < 5'd18) rom_q <= glyph_row[8*idx_q +: 8];
    else rom_q <= lmgp_pkg::EndMark;
  end

  logic [7:0] pt;
  logic [3:0] gc, gr;
  logic signed [9:0] dc, dr;
  logic       on_disp;
  logic [7:0] code;
  logic       supported;

  assign pt = rom_q;
  assign gc = pt[7:4];
  assign gr = pt[3:0];
  assign code = cmd_i.character_code;
  assign supported = (code >= 8'(lmgp_pkg::FirstCode)) && (32'(code) <= LAST_CODE) &&
                     (lmgp_pkg::glyph_slot(code) != 7'd0);

  always_comb begin
    if (cmd_q.mode) begin
      dc = 10'sd7 - 10'($signed({6'd0, gr})) + 10'($signed(cmd_q.origin_col));
      dr = 10'($signed({6'd0, gc})) + 10'($signed(cmd_q.origin_row));
    end else begin
      dc = 10'($signed({6'd0, gc})) + 10'($signed(cmd_q.origin_col));
      dr = 10'($signed({6'd0, gr})) + 10'($signed(cmd_q.origin_row));
    end
    on_disp = (dc >= 0) && (dc < $signed(10'(DISPLAY_WIDTH))) &&
              (dr >= 0) && (dr < $signed(10'(DISPLAY_HEIGHT)));
  end

  always_comb begin
    state_d   = state_q;
    idx_d     = idx_q;
    slot_d    = slot_q;
    rd_d      = 1'b0;
    cmd_d     = cmd_q;
    widest_d  = widest_q;
    fin_adv_d = fin_adv_q;
    fin_d     = 1'b0;
    res_d     = '0;
    res_v_d   = 1'b0;
    unique case (state_q)
      StIdle: begin
        if (start && !busy) begin
          cmd_d    = cmd_i;
          idx_d    = '0;
          widest_d = '0;
          slot_d   = lmgp_pkg::glyph_slot(code);
          if (code == 8'(lmgp_pkg::SpaceCode)) begin
            fin_adv_d = 3'(lmgp_pkg::SpaceAdvance);
            state_d   = StDone;
          end else if (!supported) begin
            fin_adv_d = 3'd0;
            state_d   = StDone;
          end else begin
            state_d = StWalk;
          end
        end
      end
      StWalk: begin
        // issue read at idx_q, consume the point read last cycle
        if (rd_q) begin
          if (pt == lmgp_pkg::EndMark) begin
            fin_adv_d = 3'(widest_q + 3'd2);
            state_d   = StDone;
          end else begin
            if (gc[2:0] > widest_q) widest_d = gc[2:0];
            if (on_disp) begin
              res_v_d           = 1'b1;
              res_d.pixel_write = 1'b1;
              res_d.pixel_col   = dc[3:0];
              res_d.pixel_row   = dr[3:0];
              res_d.pixel_level = cmd_q.pixel_value;
            end
          end
        end
        if (state_d == StWalk) begin
          rd_d  = 1'b1;
          idx_d = idx_q + 5'd1;
        end
      end
      StDone: begin
        res_v_d       = 1'b1;
        res_d.advance = fin_adv_q;
        res_d.last    = 1'b1;
        fin_d         = 1'b1;
        state_d       = StIdle;
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      rd_q    <= 1'b0;
      res_v_q <= 1'b0;
      fin_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      rd_q    <= rd_d;
      res_v_q <= res_v_d;
      fin_q   <= fin_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q     <= idx_d;
    slot_q    <= slot_d;
    cmd_q     <= cmd_d;
    widest_q  <= widest_d;
    fin_adv_q <= fin_adv_d;
    res_q     <= res_d;
  end

  // Hold busy until the final word has left the output register.
  assign busy        = (state_q != StIdle) || fin_q;
  assign res_valid_o = res_v_q;
  assign res_o       = res_q;

  a_last_closes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_v_q && res_q.last |-> !res_q.pixel_write)
    else $error("final word carries a pixel write");
  a_fin_with_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fin_q |-> res_v_q && res_q.last)
    else $error("final marker without final word");
  a_idx_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == StWalk |-> idx_q <= 5'(lmgp_pkg::MaxPoints + 1))
    else $error("point index ran past the glyph list");
  a_no_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_v_q && !res_q.last |-> busy)
    else $error("pixel write while idle");

endmodule
